FILE: hw/rtl/mcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code decoder package
// Shared state type, character constants and the Morse code table.
// ----------------------------------------------------------------------------
package mcd_pkg;

   localparam int unsigned CODE_MAX = 6;
   localparam int unsigned COUNT_W  = 3;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [6:0] WORD_GAP   = 7'h20;

   typedef struct packed {
      logic [CODE_MAX-1:0] symbol_bits;
      logic [COUNT_W-1:0]  symbol_count;
      logic                bad_symbol_seen;
      logic                gap_pending;
   } code_state_type;

   // Code is right-aligned in bits, first symbol most significant, dash = 1.
   // Returns 0 when the code is not in the table.
   function automatic logic [6:0] morse_lookup(input logic [COUNT_W-1:0] count,
                                               input logic [CODE_MAX-1:0] bits);
      logic [6:0] ch;
      ch = 7'h00;
      case ({count, bits})
         {3'd2, 6'd1}:  ch = 7'h41; // A
         {3'd4, 6'd8}:  ch = 7'h42; // B
         {3'd4, 6'd10}: ch = 7'h43; // C
         {3'd3, 6'd4}:  ch = 7'h44; // D
         {3'd1, 6'd0}:  ch = 7'h45; // E
         {3'd4, 6'd2}:  ch = 7'h46; // F
         {3'd3, 6'd6}:  ch = 7'h47; // G
         {3'd4, 6'd0}:  ch = 7'h48; // H
         {3'd2, 6'd0}:  ch = 7'h49; // I
         {3'd4, 6'd7}:  ch = 7'h4A; // J
         {3'd3, 6'd5}:  ch = 7'h4B; // K
         {3'd4, 6'd4}:  ch = 7'h4C; // L
         {3'd2, 6'd3}:  ch = 7'h4D; // M
         {3'd2, 6'd2}:  ch = 7'h4E; // N
         {3'd3, 6'd7}:  ch = 7'h4F; // O
         {3'd4, 6'd6}:  ch = 7'h50; // P
         {3'd4, 6'd13}: ch = 7'h51; // Q
         {3'd3, 6'd2}:  ch = 7'h52; // R
         {3'd3, 6'd0}:  ch = 7'h53; // S
         {3'd1, 6'd1}:  ch = 7'h54; // T
         {3'd3, 6'd1}:  ch = 7'h55; // U
         {3'd4, 6'd1}:  ch = 7'h56; // V
         {3'd3, 6'd3}:  ch = 7'h57; // W
         {3'd4, 6'd9}:  ch = 7'h58; // X
         {3'd4, 6'd11}: ch = 7'h59; // Y
         {3'd4, 6'd12}: ch = 7'h5A; // Z
         {3'd5, 6'd31}: ch = 7'h30; // 0
         {3'd5, 6'd15}: ch = 7'h31; // 1
         {3'd5, 6'd7}:  ch = 7'h32; // 2
         {3'd5, 6'd3}:  ch = 7'h33; // 3
         {3'd5, 6'd1}:  ch = 7'h34; // 4
         {3'd5, 6'd0}:  ch = 7'h35; // 5
         {3'd5, 6'd16}: ch = 7'h36; // 6
         {3'd5, 6'd24}: ch = 7'h37; // 7
         {3'd5, 6'd28}: ch = 7'h38; // 8
         {3'd5, 6'd30}: ch = 7'h39; // 9
         {3'd6, 6'd21}: ch = 7'h2E; // .
         {3'd6, 6'd51}: ch = 7'h2C; // ,
         {3'd6, 6'd12}: ch = 7'h3F; // ?
         {3'd6, 6'd30}: ch = 7'h27; // '
         {3'd6, 6'd43}: ch = 7'h21; // !
         {3'd5, 6'd18}: ch = 7'h2F; // /
         {3'd5, 6'd22}: ch = 7'h28; // (
         {3'd6, 6'd45}: ch = 7'h29; // )
         {3'd5, 6'd8}:  ch = 7'h26; // &
         {3'd6, 6'd56}: ch = 7'h3A; // :
         {3'd6, 6'd42}: ch = 7'h3B; // ;
         {3'd5, 6'd17}: ch = 7'h3D; // =
         {3'd5, 6'd10}: ch = 7'h2B; // +
         {3'd6, 6'd33}: ch = 7'h2D; // -
         {3'd6, 6'd13}: ch = 7'h5F; // _
         {3'd6, 6'd18}: ch = 7'h22; // "
         {3'd6, 6'd26}: ch = 7'h40; // @
         default:       ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hw/rtl/morse_code_decoder_top.sv
`timescale 1ns / 1ps
// Path: a character is held in the input register, and its result is then registered in
// the result register before it is valid on rsp_.
// Throughput: one character per cycle while rsp_tready stays high; the code state
// is updated by one pass of the step logic in each cycle in which a character advances.
// Reset: synchronous, active high; clears the code state and both valid flags.
// ----------------------------------------------------------------------------
// Morse code decoder top level
// Streams text characters in and decoded ASCII characters out.
// ----------------------------------------------------------------------------
module morse_code_decoder_top import mcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] decoded_char, [7] zero
   output logic       rsp_tuser    // [0] unknown_code
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff, in_char_in;
   code_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic [6:0]     out_char_ff, out_char_in;
   logic           out_unknown_ff, out_unknown_in;

   code_state_type state_nxt;
   logic           emit;
   logic [6:0]     dec_char;
   logic           dec_unknown;
   logic           advance;

   // The step stage moves whenever the result register is free or drains.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   mcd_decode u_decode (
      .text_char    (in_char_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_nxt),
      .emit         (emit),
      .decoded_char (dec_char),
      .unknown_code (dec_unknown)
   );

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_char_in     = in_char_ff;
      state_in       = state_ff;
      out_valid_in   = out_valid_ff;
      out_char_in    = out_char_ff;
      out_unknown_in = out_unknown_ff;
      if (advance) begin
         out_valid_in = in_valid_ff && emit;
         if (in_valid_ff) begin
            state_in       = state_nxt;
            out_char_in    = dec_char;
            out_unknown_in = dec_unknown;
         end
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff     <= in_char_in;
      out_char_ff    <= out_char_in;
      out_unknown_ff <= out_unknown_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tuser  = out_unknown_ff;

endmodule

FILE: hw/rtl/mcd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code decoder step logic
// Computes the next code state and the optional result for one character.
// ----------------------------------------------------------------------------
module mcd_decode import mcd_pkg::*; (
   input  logic [7:0]     text_char,
   input  code_state_type state_cur,
   output code_state_type state_nxt,
   output logic           emit,
   output logic [6:0]     decoded_char,
   output logic           unknown_code
);

   logic       is_space;
   logic       is_symbol;
   logic [6:0] table_char;

   assign is_space  = (text_char == CHAR_SPACE) ||
                      ((text_char >= CHAR_TAB) && (text_char <= CHAR_CR));
   assign is_symbol = (text_char == CHAR_DOT) || (text_char == CHAR_DASH);
   assign table_char = morse_lookup(state_cur.symbol_count, state_cur.symbol_bits);

   always_comb begin
      state_nxt    = state_cur;
      emit         = 1'b0;
      decoded_char = 7'h00;
      unknown_code = 1'b0;
      if (is_space) begin
         emit = 1'b1;
         if (state_cur.gap_pending) begin
            state_nxt.gap_pending = 1'b0;
            decoded_char          = WORD_GAP;
         end else begin
            if (!state_cur.bad_symbol_seen && (state_cur.symbol_count != '0)) begin
               decoded_char = table_char;
            end
            unknown_code              = (decoded_char == 7'h00);
            state_nxt.symbol_bits     = '0;
            state_nxt.symbol_count    = '0;
            state_nxt.bad_symbol_seen = 1'b0;
            state_nxt.gap_pending     = 1'b1;
         end
      end else begin
         state_nxt.gap_pending = 1'b0;
         if (is_symbol && (state_cur.symbol_count < COUNT_W'(CODE_MAX))) begin
            state_nxt.symbol_bits  = {state_cur.symbol_bits[CODE_MAX-2:0],
                                      (text_char == CHAR_DASH)};
            state_nxt.symbol_count = state_cur.symbol_count + 1'b1;
         end else begin
            // Invalid byte or a seventh symbol spoils the code.
            state_nxt.bad_symbol_seen = 1'b1;
         end
      end
   end

endmodule
